// File: sv/tca_pkg.sv
`default_nettype none
package tca_pkg;

  localparam int PRICE_WIDTH  = 48;
  localparam int AMOUNT_WIDTH = 48;
  localparam int ID_WIDTH     = 63;
  localparam int TIME_WIDTH   = 48;
  localparam int SIZE_WIDTH   = 31;
  localparam int VOL_WIDTH    = 64;
  localparam int DIVIDEND_WIDTH = 64;
  localparam int BITS_PER_CYCLE = 4;
  localparam int DIV_CYCLES   = DIVIDEND_WIDTH / BITS_PER_CYCLE;
  localparam int DIV_CNT_WIDTH = $clog2(DIV_CYCLES);
  localparam int CFG_INDEX_WIDTH = 1;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WINDOW_MODE = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WINDOW_SIZE = 1'd1;
  localparam logic [SIZE_WIDTH-1:0] WINDOW_SIZE_RESET = 31'd1000;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_TIME = 1'b1;
  localparam logic CAUSE_CROSSED = 1'b0;
  localparam logic CAUSE_TICKS   = 1'b1;

  typedef struct packed {
    logic [ID_WIDTH-1:0]     trade_number;
    logic [TIME_WIDTH-1:0]   trade_time;
    logic [PRICE_WIDTH-1:0]  trade_price;
    logic [AMOUNT_WIDTH-1:0] trade_amount;
  } trade_t;

  typedef struct packed {
    logic [PRICE_WIDTH-1:0] bar_open;
    logic [PRICE_WIDTH-1:0] bar_high;
    logic [PRICE_WIDTH-1:0] bar_low;
    logic [PRICE_WIDTH-1:0] bar_close;
    logic [VOL_WIDTH-1:0]   bar_volume;
    logic [ID_WIDTH-1:0]    bar_last_trade;
    logic [ID_WIDTH-1:0]    bar_window_start;
    logic                   close_cause;
  } bar_t;

  // classified trade handed from front to back
  typedef struct packed {
    logic [ID_WIDTH-1:0]     trade_number;
    logic [PRICE_WIDTH-1:0]  trade_price;
    logic [AMOUNT_WIDTH-1:0] trade_amount;
    logic [ID_WIDTH-1:0]     pos;
    logic [ID_WIDTH-1:0]     key;
    logic [SIZE_WIDTH-1:0]   size;
    logic                    tick_hit;
  } entry_t;

  typedef struct packed {
    logic push;
    logic full;
  } qctl_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } front_state_t;

endpackage
`default_nettype wire

// File: sv/tca_front.sv
`default_nettype none
module tca_front import tca_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire trade_t                in_data,
  input  wire logic                  mode,
  input  wire logic [SIZE_WIDTH-1:0] window_size,
  input  wire logic                  q_full,
  output logic                       q_push,
  output entry_t                     q_entry
);

  front_state_t state_r, state_nxt;
  logic [DIV_CNT_WIDTH-1:0]  cnt_r;
  logic [DIVIDEND_WIDTH-1:0] pos_sh_r, tick_sh_r;
  logic [SIZE_WIDTH-1:0]     rem_pos_r, rem_tick_r, size_r;
  logic [ID_WIDTH-1:0]       pos_r, number_r;
  logic [PRICE_WIDTH-1:0]    price_r;
  logic [AMOUNT_WIDTH-1:0]   amount_r;
  logic                      mode_r;

  logic [SIZE_WIDTH-1:0]     rem_pos_nxt, rem_tick_nxt;
  logic [DIVIDEND_WIDTH-1:0] pos_sh_nxt, tick_sh_nxt;
  logic                      accept;

  assign accept = in_valid && !in_stall;

  // restoring remainder, four dividend bits per cycle on both dividends
  always_comb begin
    logic [SIZE_WIDTH:0] ta, tb;
    rem_pos_nxt  = rem_pos_r;
    rem_tick_nxt = rem_tick_r;
    pos_sh_nxt   = pos_sh_r;
    tick_sh_nxt  = tick_sh_r;
    for (int k = 0; k < BITS_PER_CYCLE; k++) begin
      ta = {rem_pos_nxt, pos_sh_nxt[DIVIDEND_WIDTH-1]};
      tb = {rem_tick_nxt, tick_sh_nxt[DIVIDEND_WIDTH-1]};
      if (ta >= {1'b0, size_r}) ta = ta - {1'b0, size_r};
      if (tb >= {1'b0, size_r}) tb = tb - {1'b0, size_r};
      rem_pos_nxt  = ta[SIZE_WIDTH-1:0];
      rem_tick_nxt = tb[SIZE_WIDTH-1:0];
      pos_sh_nxt   = {pos_sh_nxt[DIVIDEND_WIDTH-2:0], 1'b0};
      tick_sh_nxt  = {tick_sh_nxt[DIVIDEND_WIDTH-2:0], 1'b0};
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FR_IDLE: if (in_valid) state_nxt = FR_DIV;
      FR_DIV:  if (cnt_r == DIV_CNT_WIDTH'(DIV_CYCLES - 1)) state_nxt = FR_PUSH;
      FR_PUSH: if (!q_full) state_nxt = FR_IDLE;
      default: state_nxt = FR_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != FR_IDLE);
    q_push   = (state_r == FR_PUSH) && !q_full;
  end

  always_comb begin
    q_entry.trade_number = number_r;
    q_entry.trade_price  = price_r;
    q_entry.trade_amount = amount_r;
    q_entry.pos          = pos_r;
    q_entry.key          = pos_r - {{(ID_WIDTH-SIZE_WIDTH){1'b0}}, rem_pos_r};
    q_entry.size         = size_r;
    q_entry.tick_hit     = (mode_r == MODE_TICK) && (rem_tick_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) cnt_r <= '0;
      else if (state_r == FR_DIV) cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      number_r   <= in_data.trade_number;
      price_r    <= in_data.trade_price;
      amount_r   <= in_data.trade_amount;
      mode_r     <= mode;
      size_r     <= (window_size == '0) ? SIZE_WIDTH'(1) : window_size;
      pos_r      <= (mode == MODE_TIME) ?
                    {{(ID_WIDTH-TIME_WIDTH){1'b0}}, in_data.trade_time} :
                    in_data.trade_number;
      pos_sh_r   <= (mode == MODE_TIME) ?
                    {{(DIVIDEND_WIDTH-TIME_WIDTH){1'b0}}, in_data.trade_time} :
                    {1'b0, in_data.trade_number};
      tick_sh_r  <= {1'b0, in_data.trade_number} + DIVIDEND_WIDTH'(1);
      rem_pos_r  <= '0;
      rem_tick_r <= '0;
    end else if (state_r == FR_DIV) begin
      pos_sh_r   <= pos_sh_nxt;
      tick_sh_r  <= tick_sh_nxt;
      rem_pos_r  <= rem_pos_nxt;
      rem_tick_r <= rem_tick_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/tca_queue.sv
`default_nettype none
module tca_queue import tca_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire qctl_t  ctl_in,
  output logic        full,
  input  wire entry_t wr_entry,
  input  wire logic   pop,
  output logic        not_empty,
  output entry_t      rd_entry
);

  entry_t     mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign rd_entry  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (ctl_in.push) mem_r[wr_ptr_r] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (ctl_in.push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + {1'b0, ctl_in.push} - {1'b0, pop};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl_in.push && ctl_in.full)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !not_empty)) else $error("pop from empty queue");

endmodule
`default_nettype wire

// File: sv/tca_back.sv
`default_nettype none
module tca_back import tca_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   q_not_empty,
  input  wire entry_t q_entry,
  output logic        q_pop,
  output logic        out_valid,
  input  wire logic   out_stall,
  output bar_t        out_data
);

  logic                   active_r;
  logic [PRICE_WIDTH-1:0] open_r, high_r, low_r, close_r;
  logic [VOL_WIDTH-1:0]   vol_r;
  logic [ID_WIDTH-1:0]    last_r, start_r;
  logic                   out_valid_r;
  bar_t                   out_data_r;

  logic                   crossed;
  logic                   emit;
  logic [VOL_WIDTH:0]     vol_sum;
  logic [VOL_WIDTH-1:0]   vol_nxt;
  logic [PRICE_WIDTH-1:0] high_nxt, low_nxt;

  assign q_pop     = q_not_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    crossed  = {1'b0, q_entry.pos} >=
               ({1'b0, start_r} + {{(VOL_WIDTH-SIZE_WIDTH){1'b0}}, q_entry.size});
    vol_sum  = {1'b0, vol_r} +
               {{(VOL_WIDTH+1-AMOUNT_WIDTH){1'b0}}, q_entry.trade_amount};
    vol_nxt  = vol_sum[VOL_WIDTH] ? '1 : vol_sum[VOL_WIDTH-1:0];
    high_nxt = (q_entry.trade_price > high_r) ? q_entry.trade_price : high_r;
    low_nxt  = (q_entry.trade_price < low_r) ? q_entry.trade_price : low_r;
    emit     = q_pop && active_r && (crossed || q_entry.tick_hit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      open_r      <= '0;
      high_r      <= '0;
      low_r       <= '0;
      close_r     <= '0;
      vol_r       <= '0;
      last_r      <= '0;
      start_r     <= '0;
    end else begin
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (q_pop) begin
        if (!active_r || crossed) begin
          if (active_r) begin
            out_data_r  <= '{open_r, high_r, low_r, close_r, vol_r, last_r,
                             start_r, CAUSE_CROSSED};
          end
          active_r <= 1'b1;
          open_r   <= q_entry.trade_price;
          high_r   <= q_entry.trade_price;
          low_r    <= q_entry.trade_price;
          close_r  <= q_entry.trade_price;
          vol_r    <= {{(VOL_WIDTH-AMOUNT_WIDTH){1'b0}}, q_entry.trade_amount};
          last_r   <= q_entry.trade_number;
          start_r  <= q_entry.key;
        end else begin
          high_r  <= high_nxt;
          low_r   <= low_nxt;
          close_r <= q_entry.trade_price;
          vol_r   <= vol_nxt;
          last_r  <= q_entry.trade_number;
          if (q_entry.tick_hit) begin
            active_r    <= 1'b0;
            out_data_r  <= '{open_r, high_nxt, low_nxt, q_entry.trade_price, vol_nxt,
                             q_entry.trade_number, start_r, CAUSE_TICKS};
          end
        end
      end
    end
  end

  a_low_le_high: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (low_r <= high_r)) else $error("candle low above high");
  a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !q_pop) else $error("pop while result held");
  a_tick_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r) && out_data_r.close_cause == CAUSE_TICKS)
    |-> !active_r) else $error("tick close left candle open");

endmodule
`default_nettype wire

// File: sv/trade_candle_aggregator.sv
// a new trade is accepted only once the last one is pushed, after the shared remainder unit
//   (4 dividend bits per cycle over 64 bits for window key and tick count)
// a two-entry queue separates classification from candle update
// reset (rst_n low, synchronous): no open candle, mode tick, window 1000
`default_nettype none
module trade_candle_aggregator import tca_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire trade_t                     in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output bar_t                            out_data,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [SIZE_WIDTH-1:0]      cfg_wdata
);

  logic                  mode_r;
  logic [SIZE_WIDTH-1:0] size_r;
  qctl_t                 qctl;
  entry_t                push_entry, head_entry;
  logic                  q_push, q_full, q_pop, q_not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_TICK;
      size_r <= WINDOW_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_MODE: mode_r <= cfg_wdata[0];
        CFG_WINDOW_SIZE: size_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign qctl = '{push: q_push, full: q_full};

  tca_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .mode(mode_r), .window_size(size_r),
    .q_full, .q_push(q_push), .q_entry(push_entry)
  );

  tca_queue u_queue (
    .clk, .rst_n, .ctl_in(qctl), .full(q_full), .wr_entry(push_entry),
    .pop(q_pop), .not_empty(q_not_empty), .rd_entry(head_entry)
  );

  tca_back u_back (
    .clk, .rst_n, .q_not_empty, .q_entry(head_entry), .q_pop,
    .out_valid, .out_stall, .out_data
  );

endmodule
`default_nettype wire

// File: test/tb.sv
`default_nettype none
module tb;
  import tca_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIMEOUT_CYCLES = 2_000_000;
  localparam int DRAIN_CYCLES   = 40;

  class candle_board;
    logic              mode;
    logic [SIZE_WIDTH-1:0] size_reg;
    bit                active;
    logic [47:0]       open_p, high_p, low_p, close_p;
    logic [63:0]       vol;
    logic [62:0]       last_id, key;
    bar_t              pending[$];
    int                errors;
    int                bars_seen;
    int                tick_closes;

    function void clear();
      mode = MODE_TICK;
      size_reg = WINDOW_SIZE_RESET;
      active = 0;
      pending.delete();
    endfunction

    function void start_candle(trade_t t, logic [63:0] pos, logic [63:0] sz);
      open_p = t.trade_price;
      high_p = t.trade_price;
      low_p = t.trade_price;
      close_p = t.trade_price;
      vol = {16'd0, t.trade_amount};
      last_id = t.trade_number;
      key = 63'(pos - (pos % sz));
      active = 1;
    endfunction

    function bar_t snapshot(logic cause);
      bar_t b;
      b.bar_open = open_p;
      b.bar_high = high_p;
      b.bar_low = low_p;
      b.bar_close = close_p;
      b.bar_volume = vol;
      b.bar_last_trade = last_id;
      b.bar_window_start = key;
      b.close_cause = cause;
      return b;
    endfunction

    function void note_trade(trade_t t);
      logic [63:0] sz, pos, amt, idp1;
      sz = (size_reg == 0) ? 64'd1 : {33'd0, size_reg};
      pos = (mode == MODE_TIME) ? {16'd0, t.trade_time} : {1'b0, t.trade_number};
      amt = {16'd0, t.trade_amount};
      if (!active) begin
        start_candle(t, pos, sz);
        return;
      end
      // key + size may exceed 63 bits, compare at 64
      if (pos >= {1'b0, key} + sz) begin
        pending.insert(pending.size(), snapshot(CAUSE_CROSSED));
        start_candle(t, pos, sz);
        return;
      end
      if (t.trade_price > high_p) high_p = t.trade_price;
      if (t.trade_price < low_p) low_p = t.trade_price;
      close_p = t.trade_price;
      vol = (vol > ~amt) ? '1 : vol + amt;
      last_id = t.trade_number;
      idp1 = {1'b0, t.trade_number} + 64'd1;
      if (mode == MODE_TICK && (idp1 % sz) == 0) begin
        pending.insert(pending.size(), snapshot(CAUSE_TICKS));
        active = 0;
      end
    endfunction

    function void check_bar(bar_t got);
      bar_t exp;
      bars_seen++;
      if (got.close_cause == CAUSE_TICKS) tick_closes++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t unexpected candle: exp none act %h", $time, got);
        return;
      end
      exp = pending.pop_front();
      if (got.bar_open !== exp.bar_open) begin
        errors++; $display("%0t open: exp %h act %h", $time, exp.bar_open, got.bar_open);
      end
      if (got.bar_high !== exp.bar_high) begin
        errors++; $display("%0t high: exp %h act %h", $time, exp.bar_high, got.bar_high);
      end
      if (got.bar_low !== exp.bar_low) begin
        errors++; $display("%0t low: exp %h act %h", $time, exp.bar_low, got.bar_low);
      end
      if (got.bar_close !== exp.bar_close) begin
        errors++; $display("%0t close: exp %h act %h", $time, exp.bar_close, got.bar_close);
      end
      if (got.bar_volume !== exp.bar_volume) begin
        errors++;
        $display("%0t volume: exp %h act %h", $time, exp.bar_volume, got.bar_volume);
      end
      if (got.bar_last_trade !== exp.bar_last_trade) begin
        errors++;
        $display("%0t last trade: exp %h act %h", $time, exp.bar_last_trade,
                 got.bar_last_trade);
      end
      if (got.bar_window_start !== exp.bar_window_start) begin
        errors++;
        $display("%0t window start: exp %h act %h", $time, exp.bar_window_start,
                 got.bar_window_start);
      end
      if (got.close_cause !== exp.close_cause) begin
        errors++;
        $display("%0t cause: exp %b act %b", $time, exp.close_cause, got.close_cause);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  trade_t in_data = '0;
  logic out_valid;
  logic out_stall = 1;
  bar_t out_data;
  logic cfg_we = 0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = CFG_WINDOW_MODE;
  logic [SIZE_WIDTH-1:0] cfg_wdata = '0;

  candle_board board;
  int cycles = 0;
  int trades_sent = 0;
  bit stall_quiet = 0;

  logic [62:0] next_id;
  logic [47:0] next_ts;

  trade_candle_aggregator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("[trade_candle_aggregator] ERROR");
      $finish;
    end
  end

  // result side: check on accept, randomise stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) board.check_bar(out_data);
      if (stall_quiet) out_stall <= 0;
      else out_stall <= ($urandom_range(0, 99) < 25);
    end
  end

  // valid stays high after an accept until the next call decides on a gap
  task automatic send_trade(trade_t t);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
    board.note_trade(t);
    trades_sent++;
  endtask

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [SIZE_WIDTH-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_WINDOW_MODE) board.mode = val[0];
    else board.size_reg = val;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  function automatic trade_t mk(logic [62:0] id, logic [47:0] ts, logic [47:0] p,
                                logic [47:0] a);
    trade_t t;
    t.trade_number = id;
    t.trade_time = ts;
    t.trade_price = p;
    t.trade_amount = a;
    return t;
  endfunction

  // mostly well-formed stream: ids and times advance by small steps, occasional jump back or random id and time
  task automatic random_phase(int n, int step_max);
    trade_t t;
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      next_id = next_id + 63'($urandom_range(1, step_max));
      next_ts = next_ts + 48'($urandom_range(0, step_max));
      t = mk(next_id, next_ts,
             (r < 10) ? rand48() : 48'($urandom_range(1000, 1100)),
             (r < 5) ? 48'hFFFF_FFFF_FFFF : 48'($urandom_range(0, 5000)));
      if (r >= 95) begin
        t.trade_number = 63'({$urandom, $urandom});
        t.trade_time = rand48();
      end else if (r >= 92) begin
        t.trade_number = next_id - 63'($urandom_range(0, 20));
      end
      send_trade(t);
    end
  endtask

  initial begin
    board = new();
    board.clear();
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: tick mode at reset size, crossing and tick close
    send_trade(mk(63'd5, 48'd0, 48'd100, 48'd1));
    send_trade(mk(63'd6, 48'd1, 48'd200, 48'd2));
    send_trade(mk(63'd2, 48'd2, 48'd50, 48'd3));
    send_trade(mk(63'd999, 48'd3, 48'd70, 48'd4));
    send_trade(mk(63'd1000, 48'd4, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF));
    send_trade(mk(63'd2500, 48'd5, 48'd0, 48'd0));
    drain();
    write_reg(CFG_WINDOW_SIZE, '0);
    send_trade(mk(63'h7FFF_FFFF_FFFF_FFFE, 48'hFFFF_FFFF_FFFF, 48'd1, 48'd1));
    send_trade(mk(63'h7FFF_FFFF_FFFF_FFFF, 48'd0, 48'd2, 48'd2));
    send_trade(mk(63'd0, 48'd0, 48'd3, 48'd3));
    drain();
    write_reg(CFG_WINDOW_SIZE, 31'h7FFF_FFFF);
    write_reg(CFG_WINDOW_MODE, SIZE_WIDTH'(MODE_TIME));
    send_trade(mk(63'h7FFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'd9, 48'd9));
    send_trade(mk(63'd1, 48'd0, 48'd8, 48'd8));
    send_trade(mk(63'd2, 48'hFFFF_FFFF_FFFF, 48'd7, 48'd7));
    drain();
    // large amounts summed in one time window of size 4
    write_reg(CFG_WINDOW_SIZE, 31'd4);
    write_reg(CFG_WINDOW_MODE, SIZE_WIDTH'(MODE_TIME));
    send_trade(mk(63'd10, 48'd100, 48'd5, 48'hFFFF_FFFF_FFFF));
    repeat (12) send_trade(mk(63'd11, 48'd101, 48'd6, 48'hFFFF_FFFF_FFFF));
    send_trade(mk(63'd12, 48'd200, 48'd6, 48'd1));
    drain();

    next_id = 0;
    next_ts = 0;
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(CFG_WINDOW_MODE, SIZE_WIDTH'(ph % 2));
      case (ph % 4)
        0: write_reg(CFG_WINDOW_SIZE, 31'd1);
        1: write_reg(CFG_WINDOW_SIZE, 31'($urandom_range(2, 6)));
        2: write_reg(CFG_WINDOW_SIZE, 31'($urandom_range(7, 40)));
        default: write_reg(CFG_WINDOW_SIZE,
                           (ph == 11) ? 31'h7FFF_FFFF : 31'($urandom_range(41, 200)));
      endcase
      stall_quiet = (ph == 5);
      random_phase(155, (ph % 4 == 3) ? 60 : 6);
      drain();
    end
    stall_quiet = 0;

    $display("sent %0d trades, checked %0d candles (%0d closed by tick count)",
             trades_sent, board.bars_seen, board.tick_closes);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("[trade_candle_aggregator] OK");
    end else begin
      $display("[trade_candle_aggregator] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
sv/tca_pkg.sv
sv/tca_front.sv
sv/tca_queue.sv
sv/tca_back.sv
sv/trade_candle_aggregator.sv
test/tb.sv
